>>> rtl/r2a_pkg.sv
// ----------------------------------------------------------------------------
// r2a_pkg
// Shared constants, types and helpers of the radix to ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package r2a_pkg;

	localparam int VALUE_BITS = 31;
	// radix 2 needs one digit per value bit
	localparam int NUM_CELLS  = VALUE_BITS;
	localparam int RADIX_W    = 6;
	localparam int DIGIT_W    = 6;
	localparam int CHAR_W     = 7;
	localparam int CNT_W      = $clog2(VALUE_BITS + NUM_CELLS);

	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	localparam logic [CHAR_W-1:0]  NUM_BASE   = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  ALPHA_BASE = CHAR_W'(55);
	localparam logic [DIGIT_W-1:0] NUM_TOP    = DIGIT_W'(9);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [DIGIT_W-1:0]    digit_t;
	typedef logic [CHAR_W-1:0]     char_t;
	typedef logic [RADIX_W-1:0]    radix_t;

	// broadcast control to every cell
	typedef struct packed {
		logic clear;  // start of a new conversion
		logic shift;  // move digits one cell toward the top
	} ctl_t;

	function automatic char_t digit_to_char(input digit_t d);
		char_t base;
		base = (d > NUM_TOP) ? ALPHA_BASE : NUM_BASE;
		return CHAR_W'(d) + base;
	endfunction

	function automatic radix_t clamp_radix(input radix_t r);
		radix_t res;
		res = r;
		if (r < RADIX_MIN) res = RADIX_MIN;
		if (r > RADIX_MAX) res = RADIX_MAX;
		return res;
	endfunction

endpackage

`default_nettype wire

>>> rtl/r2a_if.sv
// ----------------------------------------------------------------------------
// r2a_if
// Valid/ready channels of the radix to ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

interface r2a_in_if;
	logic                  valid;
	logic                  ready;
	r2a_pkg::value_t       value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface r2a_out_if;
	logic                  valid;
	logic                  ready;
	r2a_pkg::char_t        digit_char;
	logic                  last_digit;
	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

interface r2a_cfg_if;
	logic                  valid;
	logic                  ready;
	r2a_pkg::radix_t       radix;
	modport source (output valid, output radix, input ready);
	modport sink   (input valid, input radix, output ready);
endinterface

`default_nettype wire

>>> rtl/r2a_cell.sv
// ----------------------------------------------------------------------------
// r2a_cell
// One base-k digit: doubles itself plus the carry from the cell below and
// hands its own carry up; in the emit phase it shifts toward the top.
// ----------------------------------------------------------------------------
`default_nettype none

module r2a_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire r2a_pkg::ctl_t   ctl,
	input  wire r2a_pkg::radix_t radix,
	input  wire logic            seed,
	input  wire logic            en_in,
	input  wire logic            carry_in,
	input  wire r2a_pkg::digit_t digit_in,
	input  wire logic            mark_in,
	output logic                 en_out,
	output logic                 carry_out,
	output r2a_pkg::digit_t      digit_out,
	output logic                 mark_out
);

	logic            en_q;
	logic            carry_q;
	logic            mark_q;
	r2a_pkg::digit_t digit_q;

	logic [r2a_pkg::DIGIT_W:0] dbl;
	logic                      ge;
	r2a_pkg::digit_t           digit_nxt;

	assign dbl       = {digit_q, carry_in};
	assign ge        = dbl >= {1'b0, radix};
	assign digit_nxt = ge ? r2a_pkg::DIGIT_W'(dbl - {1'b0, radix})
	                      : dbl[r2a_pkg::DIGIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b0;
			carry_q <= 1'b0;
			mark_q  <= 1'b0;
		end else if (ctl.clear) begin
			en_q    <= 1'b0;
			carry_q <= 1'b0;
			mark_q  <= seed;
		end else begin
			// the step enable travels up one cell per cycle, with the carry
			en_q    <= en_in;
			carry_q <= en_in & ge;
			if (ctl.shift) begin
				mark_q <= mark_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (en_in) begin
			digit_q <= digit_nxt;
		end else if (ctl.shift) begin
			digit_q <= digit_in;
		end
	end

	assign en_out    = en_q;
	assign carry_out = carry_q;
	assign digit_out = digit_q;
	assign mark_out  = mark_q;

endmodule

`default_nettype wire

>>> rtl/r2a_chain.sv
// ----------------------------------------------------------------------------
// r2a_chain
// Row of digit cells, least significant cell first.
// ----------------------------------------------------------------------------
`default_nettype none

module r2a_chain (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire r2a_pkg::ctl_t   ctl,
	input  wire r2a_pkg::radix_t radix,
	input  wire logic            step_en,
	input  wire logic            bit_in,
	output r2a_pkg::digit_t      top_digit,
	output logic                 top_mark
);

	logic            en   [r2a_pkg::NUM_CELLS+1];
	logic            carry[r2a_pkg::NUM_CELLS+1];
	r2a_pkg::digit_t digit[r2a_pkg::NUM_CELLS+1];
	logic            mark [r2a_pkg::NUM_CELLS+1];

	assign en[0]    = step_en;
	assign carry[0] = bit_in;
	assign digit[0] = '0;
	assign mark[0]  = 1'b0;

	for (genvar i = 0; i < r2a_pkg::NUM_CELLS; i++) begin : g_cell
		r2a_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.radix     (radix),
			.seed      ((i == 0) ? 1'b1 : 1'b0),
			.en_in     (en[i]),
			.carry_in  (carry[i]),
			.digit_in  (digit[i]),
			.mark_in   (mark[i]),
			.en_out    (en[i+1]),
			.carry_out (carry[i+1]),
			.digit_out (digit[i+1]),
			.mark_out  (mark[i+1])
		);
	end

	assign top_digit = digit[r2a_pkg::NUM_CELLS];
	assign top_mark  = mark[r2a_pkg::NUM_CELLS];

endmodule

`default_nettype wire

>>> rtl/radix_to_ascii_converter.sv
// ----------------------------------------------------------------------------
// radix_to_ascii_converter
// Writes a value as ASCII digits in a radix from 2 to 36, MSD first.
// ----------------------------------------------------------------------------
// One value at a time. The value bits enter a row of 31 base-k digit cells,
// MSB first, one bit per cycle; each cell passes its carry to the next one
// through a register. The digits then shift out of the top cell one per cycle
// while the output side is free: leading zeros are skipped, one shift step
// each, then one character per cycle while the output side takes them, the
// final one flagged with last_digit. A value of zero gives no transaction on
// the output. The next value is taken only once the last digit has shifted
// out and the block is back in idle. The user must write the radix register
// only while no value is in work; the block itself does not enforce this.
// Codes below 2 act as 2 and codes above 36 act as 36.
`default_nettype none

module radix_to_ascii_converter (
	input  wire logic  clk,
	input  wire logic  arst_n,
	r2a_in_if.sink     in_ch,
	r2a_out_if.source  out_ch,
	r2a_cfg_if.sink    cfg
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic [r2a_pkg::CNT_W-1:0] CONV_LAST =
		r2a_pkg::CNT_W'(r2a_pkg::VALUE_BITS + r2a_pkg::NUM_CELLS - 2);
	localparam logic [r2a_pkg::CNT_W-1:0] BITS_END =
		r2a_pkg::CNT_W'(r2a_pkg::VALUE_BITS);

	logic [1:0]                state_q;
	logic [r2a_pkg::CNT_W-1:0] cnt_q;
	r2a_pkg::value_t           val_q;
	r2a_pkg::radix_t           radix_q;
	logic                      started_q;
	logic                      out_valid_q;
	r2a_pkg::char_t            out_char_q;
	logic                      out_last_q;

	r2a_pkg::ctl_t             ctl;
	r2a_pkg::digit_t           top_digit;
	logic                      top_mark;
	logic                      in_acc;
	logic                      out_free;
	logic                      emit_step;
	logic                      emit_char;

	assign in_acc    = in_ch.valid & in_ch.ready;
	assign out_free  = ~out_valid_q | out_ch.ready;
	assign emit_step = (state_q == ST_EMIT) & out_free;
	assign emit_char = emit_step & (started_q | (top_digit != '0));

	assign ctl.clear = in_acc;
	assign ctl.shift = emit_step;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;

	r2a_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.radix     (r2a_pkg::clamp_radix(radix_q)),
		.step_en   ((state_q == ST_CONV) && (cnt_q < BITS_END)),
		.bit_in    (val_q[r2a_pkg::VALUE_BITS-1]),
		.top_digit (top_digit),
		.top_mark  (top_mark)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			radix_q     <= r2a_pkg::RADIX_RESET;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				radix_q <= cfg.radix;
			end
			if (emit_char) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q   <= ST_CONV;
						cnt_q     <= '0;
						started_q <= 1'b0;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CONV_LAST) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_char) begin
						started_q <= 1'b1;
					end
					// the mark sits on the least significant digit
					if (emit_step && top_mark) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q <= in_ch.value;
		end else if (state_q == ST_CONV) begin
			val_q <= {val_q[r2a_pkg::VALUE_BITS-2:0], 1'b0};
		end
		if (emit_char) begin
			out_char_q <= r2a_pkg::digit_to_char(top_digit);
			out_last_q <= top_mark;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.digit_char = out_char_q;
	assign out_ch.last_digit = out_last_q;

endmodule

`default_nettype wire

>>> tb/sv/radix_to_ascii_converter_checker.sv
// ----------------------------------------------------------------------------
// radix_to_ascii_converter_checker
// Watches the value, character and radix channels of the converter. Every
// accepted value is expanded into the characters it should produce under
// the radix that was last written. Each character transaction is then checked
// in order against them.
// ----------------------------------------------------------------------------
module radix_to_ascii_converter_checker
	import r2a_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	r2a_in_if          in_ch,
	r2a_out_if         out_ch,
	r2a_cfg_if         cfg,
	output int         outstanding,
	output int         fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		char_t ch;
		logic  last;
	} char_exp_t;

	char_exp_t   char_q[$];
	char_exp_t   head;
	radix_t      radix_reg;
	int unsigned chars_seen;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch at char %0d: %s", $realtime, chars_seen, msg);
		fail_count++;
	endtask

	// expand a value into its digit characters, most significant first
	function automatic void queue_chars(input value_t v, input radix_t r);
		int unsigned     base;
		longint unsigned rest;
		digit_t          digits[VALUE_BITS];
		int              n;
		char_exp_t       e;
		base = r;
		if (r < RADIX_MIN) base = RADIX_MIN;
		if (r > RADIX_MAX) base = RADIX_MAX;
		rest = v;
		n = 0;
		while (rest != 0) begin
			digits[n] = digit_t'(rest % base);
			rest = rest / base;
			n++;
		end
		for (int k = n - 1; k >= 0; k--) begin
			if (digits[k] > NUM_TOP) begin
				e.ch = ALPHA_BASE + char_t'(digits[k]);
			end else begin
				e.ch = NUM_BASE + char_t'(digits[k]);
			end
			e.last = (k == 0);
			char_q.push_back(e);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q.delete();
			radix_reg   <= RADIX_RESET;
			outstanding <= 0;
			chars_seen  = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				radix_reg <= cfg.radix;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (char_q.size() == 0) begin
					report_mismatch($sformatf("unexpected char 0x%0h last %0b",
						out_ch.digit_char, out_ch.last_digit));
				end else begin
					head = char_q.pop_front();
					if (out_ch.digit_char !== head.ch)
						report_mismatch($sformatf("digit_char 0x%0h, expected 0x%0h",
							out_ch.digit_char, head.ch));
					if (out_ch.last_digit !== head.last)
						report_mismatch($sformatf("last_digit %0b, expected %0b",
							out_ch.last_digit, head.last));
				end
				chars_seen++;
			end
			if (in_ch.valid && in_ch.ready) begin
				queue_chars(in_ch.value, radix_reg);
			end
			outstanding <= char_q.size();
		end
	end

endmodule

>>> tb/sv/radix_to_ascii_converter_tb.sv
// ----------------------------------------------------------------------------
// radix_to_ascii_converter_tb
// Stimulus and verdict for the radix to ASCII converter. A directed pass over
// the field extremes and out-of-range radix codes is followed by random
// phases, each under its own radix, most with random gaps on the value side
// and random stalls on the character side. The checker does all comparison.
// ----------------------------------------------------------------------------
module radix_to_ascii_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import r2a_pkg::*;

	localparam int MAX_WAIT        = 16;
	localparam int WATCHDOG_LIMIT  = 5000;
	// a zero value still keeps the block busy for a full conversion
	localparam int SETTLE_CYCLES   = 120;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 18;

	logic clk;
	logic arst_n;
	bit   idle_on;
	int   idle_cycles = 0;
	int   outstanding;
	int   fail_count;

	r2a_in_if  in_ch();
	r2a_out_if out_ch();
	r2a_cfg_if cfg_ch();

	radix_to_ascii_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	radix_to_ascii_converter_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg         (cfg_ch),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int draw_wait();
		return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
	endfunction

	function automatic value_t rand_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1, 2:    return value_t'($urandom_range(1, 2000));
			3:       return {VALUE_BITS{1'b1}} >> $urandom_range(0, VALUE_BITS - 1);
			default: return value_t'($urandom());
		endcase
	endfunction

	// valid stays high across back-to-back transactions
	task automatic send_value(input value_t v);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= v;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_radix(input radix_t r);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.radix <= r;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// character side: stall a random number of cycles after each transaction
	initial begin
		int hold;
		out_ch.ready = 1'b0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				if (hold == 0) out_ch.ready <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				hold = draw_wait();
				if (hold > 0) out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		radix_t plan[RANDOM_PHASES];
		in_ch.valid  = 1'b0;
		in_ch.value  = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.radix = '0;
		idle_on      = 1'b1;
		arst_n       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// radix left at its reset value
		send_value('0);
		send_value(value_t'(1));
		send_value(value_t'(9));
		send_value(value_t'(10));
		send_value('1);
		// longest run, alternating bits
		set_radix(RADIX_MIN);
		send_value(value_t'(1));
		send_value('1);
		send_value(value_t'(32'h4000_0000));
		send_value(value_t'(32'h2AAA_AAAA));
		// top letter and the roll into two digits
		set_radix(RADIX_MAX);
		send_value(value_t'(35));
		send_value(value_t'(36));
		send_value('1);
		send_value(value_t'(10));
		// codes outside 2..36 clamp to the nearest end
		set_radix(radix_t'(0));
		send_value(value_t'(5));
		set_radix(radix_t'(1));
		send_value(value_t'(6));
		set_radix(radix_t'(63));
		send_value(value_t'(71));
		set_radix(radix_t'(37));
		send_value(value_t'(35));
		set_radix(radix_t'(16));
		send_value('1);
		send_value('0);
		send_value(value_t'(32'h5555_5555));

		plan = '{RADIX_MIN, RADIX_MAX, RADIX_RESET, radix_t'(16), radix_t'(1),
			radix_t'(63), radix_t'(0), radix_t'(0)};
		plan[6] = radix_t'($urandom_range(2, 36));
		plan[7] = radix_t'($urandom_range(0, 63));
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_on = (p % 3 != 2);
			set_radix(plan[p]);
			repeat (ITEMS_PER_PHASE) send_value(rand_value());
		end
		drain();

		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
